// ----- rtl/lsvg_pkg.sv -----
// shared types, codes and constants of the lidar sector velocity guard
package lsvg_pkg;

  // sector geometry
  localparam int SECTOR_COUNT       = 5;
  localparam int MAX_SECTOR_LEN_DEF = 1024;
  localparam int SEC_NUM_W          = 3;

  // field widths
  localparam int VEL_W   = 16;
  localparam int RANGE_W = 16;
  localparam int SLEN_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [RANGE_W-1:0] RANGE_MAX       = 16'hFFFF;
  localparam logic [RANGE_W-1:0] THRESHOLD_RESET = 16'd1000;
  localparam logic [SLEN_W-1:0]  SECTOR_LEN_RESET = 11'd144;

  // sector positions in the scan
  localparam logic [SEC_NUM_W-1:0] SEC_RIGHT       = 3'd0;
  localparam logic [SEC_NUM_W-1:0] SEC_FRONT_RIGHT = 3'd1;
  localparam logic [SEC_NUM_W-1:0] SEC_FRONT       = 3'd2;
  localparam logic [SEC_NUM_W-1:0] SEC_FRONT_LEFT  = 3'd3;
  localparam logic [SEC_NUM_W-1:0] SEC_LEFT        = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_MM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_LENGTH = 2'd2;

  // word kinds
  localparam logic FUNC_CMD    = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // drive modes, the unused code acts as off
  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_MANUAL  = 2'd1,
    MODE_GUARDED = 2'd2
  } mode_e;

  // per-sector blocking flags
  typedef struct packed {
    logic left;
    logic fwd_left;
    logic front;
    logic fwd_right;
    logic right;
  } blocked_t;

endpackage

// ----- rtl/lsvg_rules.sv -----
// ordered blocking rules applied to the stored velocity at end of scan
module lsvg_rules (
  input  lsvg_pkg::blocked_t                   blk_i,
  input  logic signed [lsvg_pkg::VEL_W-1:0]    lin_i,
  input  logic signed [lsvg_pkg::VEL_W-1:0]    ang_i,
  output logic signed [lsvg_pkg::VEL_W-1:0]    lin_o,
  output logic signed [lsvg_pkg::VEL_W-1:0]    ang_o
);

  logic signed [lsvg_pkg::VEL_W-1:0] lin;
  logic signed [lsvg_pkg::VEL_W-1:0] ang;

  // rules act in order, each on the result of the one before
  always_comb begin
    lin = lin_i;
    ang = ang_i;
    // front
    if (blk_i.front && lin > 0 && ang == 0) begin
      lin = '0;
    end
    // front-left
    if (blk_i.fwd_left && lin > 0 && ang > 0) begin
      lin = '0;
      ang = '0;
    end
    // front-right
    if (blk_i.fwd_right && lin > 0 && ang < 0) begin
      lin = '0;
      ang = '0;
    end
    // left turn on the spot
    if (blk_i.left && lin == 0 && ang > 0) begin
      ang = '0;
    end
    // right turn on the spot
    if (blk_i.right && lin == 0 && ang < 0) begin
      ang = '0;
    end
    lin_o = lin;
    ang_o = ang;
  end

endmodule

// ----- rtl/lidar_sector_velocity_guard.sv -----
// top level of the lidar sector velocity guard
// a result word is registered in the input register when its input word is accepted,
//   then in the output register when it commits, which waits while a held result is not taken
// throughput: one word per cycle while no held result stalls it, set by the combinational sector compare and rule chain
// reset: modes off, threshold 1000 mm, sector length 144, velocity zero,
//   all sector minima 65535 and scan position zero; no clearing pass
module lidar_sector_velocity_guard #(
  parameter int MAX_SECTOR_LEN = lsvg_pkg::MAX_SECTOR_LEN_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration write channel
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [lsvg_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [lsvg_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // input channel
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    func_i,
  input  logic signed [lsvg_pkg::VEL_W-1:0]       linear_cmd_i,
  input  logic signed [lsvg_pkg::VEL_W-1:0]       angular_cmd_i,
  input  logic [lsvg_pkg::RANGE_W-1:0]            range_mm_i,
  input  logic                                    last_sample_i,
  // result channel
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [lsvg_pkg::VEL_W-1:0]       linear_out_o,
  output logic signed [lsvg_pkg::VEL_W-1:0]       angular_out_o
);

  localparam int PW = (MAX_SECTOR_LEN > 1) ? $clog2(MAX_SECTOR_LEN) : 1;
  localparam int LW = $clog2(MAX_SECTOR_LEN + 1);
  localparam int CW = (LW > lsvg_pkg::SLEN_W) ? LW : lsvg_pkg::SLEN_W;
  localparam int NS = lsvg_pkg::SECTOR_COUNT;

  // configuration registers
  logic [1:0]                       drive_mode_q;
  logic [lsvg_pkg::RANGE_W-1:0]     threshold_q;
  logic [lsvg_pkg::SLEN_W-1:0]      sector_len_q;

  // input register
  logic                             s1_valid_q;
  logic                             s1_func_q;
  logic signed [lsvg_pkg::VEL_W-1:0] s1_lin_q;
  logic signed [lsvg_pkg::VEL_W-1:0] s1_ang_q;
  logic [lsvg_pkg::RANGE_W-1:0]     s1_range_q;
  logic                             s1_last_q;

  // block state
  logic signed [lsvg_pkg::VEL_W-1:0] lin_q, lin_d;
  logic signed [lsvg_pkg::VEL_W-1:0] ang_q, ang_d;
  logic [lsvg_pkg::RANGE_W-1:0]     sec_min_q [NS];
  logic [lsvg_pkg::RANGE_W-1:0]     sec_min_d [NS];
  logic [lsvg_pkg::SEC_NUM_W-1:0]   sec_num_q, sec_num_d;
  logic [PW-1:0]                    pos_q, pos_d;

  // output register
  logic                             out_valid_q;
  logic signed [lsvg_pkg::VEL_W-1:0] out_lin_q, out_lin_d;
  logic signed [lsvg_pkg::VEL_W-1:0] out_ang_q, out_ang_d;

  logic                             guarded;
  logic                             manual;
  logic                             produces_res;
  logic                             advance;
  logic                             commit_res;
  logic                             take;
  logic [CW-1:0]                    len_ext;
  logic [CW-1:0]                    max_ext;
  logic [CW-1:0]                    len_eff;
  logic [PW:0]                      pos_inc;
  logic                             wrap;
  logic [lsvg_pkg::RANGE_W-1:0]     min_upd [NS];
  lsvg_pkg::blocked_t               blk;
  logic signed [lsvg_pkg::VEL_W-1:0] rule_lin;
  logic signed [lsvg_pkg::VEL_W-1:0] rule_ang;

  assign cfg_ready_o = 1'b1;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_mode_q <= lsvg_pkg::MODE_OFF;
      threshold_q  <= lsvg_pkg::THRESHOLD_RESET;
      sector_len_q <= lsvg_pkg::SECTOR_LEN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lsvg_pkg::CFG_DRIVE_MODE:    drive_mode_q <= cfg_data_i[1:0];
        lsvg_pkg::CFG_THRESHOLD_MM:  threshold_q  <= cfg_data_i;
        lsvg_pkg::CFG_SECTOR_LENGTH: sector_len_q <= cfg_data_i[lsvg_pkg::SLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake control
  assign guarded = (drive_mode_q == lsvg_pkg::MODE_GUARDED);
  assign manual  = (drive_mode_q == lsvg_pkg::MODE_MANUAL);
  assign produces_res = (s1_func_q == lsvg_pkg::FUNC_CMD) ? manual : (guarded && s1_last_q);
  assign advance    = s1_valid_q && (!produces_res || !out_valid_q || out_ready_i);
  assign commit_res = advance && produces_res;
  assign in_ready_o = !s1_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_func_q  <= func_i;
      s1_lin_q   <= linear_cmd_i;
      s1_ang_q   <= angular_cmd_i;
      s1_range_q <= range_mm_i;
      s1_last_q  <= last_sample_i;
    end
  end

  // effective sector length, clamped to the maximum
  assign len_ext = CW'(sector_len_q);
  assign max_ext = CW'(MAX_SECTOR_LEN);
  assign len_eff = (len_ext > max_ext) ? max_ext : len_ext;

  // sample lands in a sector only while sectors remain
  assign take = advance && (s1_func_q == lsvg_pkg::FUNC_SAMPLE) && guarded &&
                (len_eff != '0) && (sec_num_q < lsvg_pkg::SEC_NUM_W'(NS));
  assign pos_inc = {1'b0, pos_q} + (PW+1)'(1);
  assign wrap    = ((CW+1)'(pos_inc) >= {1'b0, len_eff});

  // running minimum of the current sector
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (take && (sec_num_q == lsvg_pkg::SEC_NUM_W'(i)) && (s1_range_q < sec_min_q[i])) begin
        min_upd[i] = s1_range_q;
      end else begin
        min_upd[i] = sec_min_q[i];
      end
    end
  end

  // blocking flags from the minima including this sample
  assign blk.right     = min_upd[lsvg_pkg::SEC_RIGHT]       < threshold_q;
  assign blk.fwd_right = min_upd[lsvg_pkg::SEC_FRONT_RIGHT] < threshold_q;
  assign blk.front     = min_upd[lsvg_pkg::SEC_FRONT]       < threshold_q;
  assign blk.fwd_left  = min_upd[lsvg_pkg::SEC_FRONT_LEFT]  < threshold_q;
  assign blk.left      = min_upd[lsvg_pkg::SEC_LEFT]        < threshold_q;

  lsvg_rules u_rules (
    .blk_i (blk),
    .lin_i (lin_q),
    .ang_i (ang_q),
    .lin_o (rule_lin),
    .ang_o (rule_ang)
  );

  // next state of velocity, scan tracking and result
  always_comb begin
    lin_d     = lin_q;
    ang_d     = ang_q;
    sec_min_d = min_upd;
    sec_num_d = sec_num_q;
    pos_d     = pos_q;
    out_lin_d = out_lin_q;
    out_ang_d = out_ang_q;
    if (take) begin
      if (wrap) begin
        pos_d     = '0;
        sec_num_d = sec_num_q + lsvg_pkg::SEC_NUM_W'(1);
      end else begin
        pos_d = pos_inc[PW-1:0];
      end
    end
    if (advance) begin
      if (s1_func_q == lsvg_pkg::FUNC_CMD) begin
        if (manual) begin
          out_lin_d = s1_lin_q;
          out_ang_d = s1_ang_q;
        end else if (guarded) begin
          lin_d = s1_lin_q;
          ang_d = s1_ang_q;
        end
      end else if (s1_last_q) begin
        if (guarded) begin
          lin_d     = rule_lin;
          ang_d     = rule_ang;
          out_lin_d = rule_lin;
          out_ang_d = rule_ang;
        end
        // end of scan clears tracking in every mode
        for (int i = 0; i < NS; i++) begin
          sec_min_d[i] = lsvg_pkg::RANGE_MAX;
        end
        sec_num_d = '0;
        pos_d     = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q     <= '0;
      ang_q     <= '0;
      sec_num_q <= '0;
      pos_q     <= '0;
      for (int i = 0; i < NS; i++) begin
        sec_min_q[i] <= lsvg_pkg::RANGE_MAX;
      end
    end else begin
      lin_q     <= lin_d;
      ang_q     <= ang_d;
      sec_num_q <= sec_num_d;
      pos_q     <= pos_d;
      sec_min_q <= sec_min_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_res) begin
      out_lin_q <= out_lin_d;
      out_ang_q <= out_ang_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign linear_out_o  = out_lin_q;
  assign angular_out_o = out_ang_q;

  // sector counter never passes the sector count
  a_sec_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_num_q <= lsvg_pkg::SEC_NUM_W'(NS))
    else $error("sector number out of range");

  // position within a sector stays below the maximum length
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PW+1)'(pos_q) < (PW+1)'(MAX_SECTOR_LEN))
    else $error("sector position out of range");

  // end of scan leaves tracking cleared
  a_scan_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_func_q == lsvg_pkg::FUNC_SAMPLE && s1_last_q) |=>
      (sec_num_q == '0 && pos_q == '0 &&
       sec_min_q[lsvg_pkg::SEC_FRONT] == lsvg_pkg::RANGE_MAX))
    else $error("scan tracking not cleared");

  // a new result only follows a committing word
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(commit_res))
    else $error("result without a committing word");

  // input side stalls only behind a held word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without cause");

endmodule
